### rtl/sf_pkg.sv
// Shared types, constants and helper functions of the stereo flanger.
// Used by every module of the block; depends on nothing else.
package sf_pkg;

  localparam int LINE_DEPTH  = 2048;
  localparam int LINE_AW     = $clog2(LINE_DEPTH);
  localparam int LEN_W       = LINE_AW + 1;
  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_FRAC  = 8;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);

  // Shared serial multiplier: signed multiplicand times unsigned multiplier.
  localparam int MUL_AW = SAMPLE_BITS;
  localparam int MUL_BW = 19;
  localparam int MUL_PW = MUL_AW + MUL_BW + 1;

  // Serial remainder unit width (delay position in samples with fraction).
  localparam int MOD_W = LEN_W + DELAY_FRAC;

  localparam int FB_LIMIT = 62259;
  localparam int MIX_ONE  = 65536;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PHASE_STEP = 3'd0;
  localparam logic [2:0] CFG_MODE       = 3'd1;
  localparam logic [2:0] CFG_RIGHT_OFS  = 3'd2;
  localparam logic [2:0] CFG_BASE_DELAY = 3'd3;
  localparam logic [2:0] CFG_SWING      = 3'd4;
  localparam logic [2:0] CFG_FEEDBACK   = 3'd5;
  localparam logic [2:0] CFG_WET_MIX    = 3'd6;
  localparam logic [2:0] CFG_LINE_LEN   = 3'd7;

  // LFO shape codes in mode bits 1:0.
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [1:0] SHAPE_SAWTOOTH = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [15:0] sine_tab_t [0:SINE_DEPTH];

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic [MUL_BW-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] num;
    logic [MOD_W-1:0] den;
  } mod_req_t;

  // Quarter-wave sine, Q1.15, from a fixed odd polynomial with Q30 coefficients.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] s;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      t  = (64'(k) << 30) / SINE_DEPTH;
      t2 = (t * t) >> 30;
      r  = 64'd5026995 - ((t2 * 64'd172272) >> 30);
      r  = 64'd85569306 - ((t2 * r) >> 30);
      r  = 64'd693598668 - ((t2 * r) >> 30);
      r  = 64'd1686629713 - ((t2 * r) >> 30);
      s  = (((t * r) >> 30) + (64'd1 << 14)) >> 15;
      tab[k] = (s > 64'd32767) ? 16'd32767 : s[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Saturate a wide signed value to the sample range.
  function automatic sample_t sat_sample(input logic signed [MUL_PW:0] v);
    logic signed [MUL_PW:0] hi;
    logic signed [MUL_PW:0] lo;
    hi = (MUL_PW + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    lo = -hi - (MUL_PW + 1)'(1);
    if (v > hi) return sample_t'(hi[SAMPLE_BITS-1:0]);
    if (v < lo) return sample_t'(lo[SAMPLE_BITS-1:0]);
    return sample_t'(v[SAMPLE_BITS-1:0]);
  endfunction

endpackage

### rtl/sf_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on sf_pkg for the request struct and widths.
module sf_mul import sf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mul_req_t                 req_i,
  output logic                     done_o,
  output logic signed [MUL_PW-1:0] prod_o
);

  logic                     busy_q;
  logic                     done_q;
  logic signed [MUL_PW-1:0] acc_q;
  logic signed [MUL_PW-1:0] a_q;
  logic [MUL_BW-1:0]        b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !req_i.start && (b_q[MUL_BW-1:1] == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q[MUL_BW-1:1] == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Stops as soon as no multiplier bits remain.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= MUL_PW'(req_i.a);
      b_q   <= req_i.b;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/sf_mod.sv
// Bit-serial restoring remainder unit, one numerator bit per cycle.
// Depends on sf_pkg for the request struct and widths.
module sf_mod import sf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mod_req_t         req_i,
  output logic             done_o,
  output logic [MOD_W-1:0] rem_o
);

  localparam int CW = $clog2(MOD_W);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [MOD_W-1:0] num_q;
  logic [MOD_W-1:0] den_q;
  logic [MOD_W-1:0] rem_q;
  logic [MOD_W:0]   trial;

  assign trial = {rem_q, num_q[MOD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MOD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_q <= MOD_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[MOD_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### rtl/sf_lfo.sv
// LFO waveform generator: sine from a quarter-wave table, triangle, sawtooth.
// Two register stages; depends on sf_pkg for the sine table and shape codes.
module sf_lfo import sf_pkg::*; (
  input  logic               clk_i,
  input  logic [31:0]        phase_i,
  input  logic [1:0]         shape_i,
  output logic signed [16:0] lfo_o
);

  logic [SINE_AW:0]   idx;
  logic signed [17:0] ramp;
  logic [15:0]        tab_q;
  logic               neg_q;
  logic               sine_q;
  logic signed [16:0] ramp_q;
  logic signed [16:0] lfo_q;
  logic signed [16:0] tab_ext;

  always_comb begin
    idx = {1'b0, phase_i[29 -: SINE_AW]};
    if (phase_i[30]) begin
      idx = (SINE_AW + 1)'(SINE_DEPTH) - idx;
    end
    case (shape_i)
      SHAPE_TRIANGLE: begin
        if (!phase_i[31]) ramp = $signed({1'b0, phase_i[31:15]}) - 18'sd32768;
        else              ramp = 18'sd98304 - $signed({1'b0, phase_i[31:15]});
      end
      SHAPE_SAWTOOTH: ramp = 18'sd32768 - $signed({2'b0, phase_i[31:16]});
      default:        ramp = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tab_q  <= SINE_TAB[idx];
    neg_q  <= phase_i[31];
    sine_q <= (shape_i != SHAPE_TRIANGLE) && (shape_i != SHAPE_SAWTOOTH);
    ramp_q <= ramp[16:0];
  end

  assign tab_ext = $signed({1'b0, tab_q});

  always_ff @(posedge clk_i) begin
    if (sine_q) lfo_q <= neg_q ? -tab_ext : tab_ext;
    else        lfo_q <= ramp_q;
  end

  assign lfo_o = lfo_q;

endmodule

### rtl/stereo_flanger.sv
// Stereo flanger top level: sequencer, delay-line memories and configuration.
// Depends on sf_pkg, sf_mul, sf_mod and sf_lfo.
//
// Takes one left/right Q1.23 request per item and returns one processed pair.
// After reset the block runs a clearing pass over both 2048-entry delay lines,
// during which in_stall_o stays high; configuration writes are taken at any
// time. Each channel is worked through one step at a time by a single
// bit-serial multiplier (six products per channel) and a bit-serial remainder
// unit for the delay wrap, so the time one channel takes depends on the
// operands; with stereo off the right input is passed straight through and
// only the left channel is computed. The next request is taken as soon as the
// result sits in the output register; only when the following result is also
// ready does a stalled output hold the sequencer.
// Configuration is meant to be written while the block is idle.
module stereo_flanger import sf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] left_in_i,
  input  logic [23:0] right_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] left_out_o,
  output logic [23:0] right_out_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDOLD, S_LFO, S_FBSTART, S_FBMUL, S_DMUL, S_MOD,
    S_RD0, S_RD1, S_RD2, S_M0, S_M1, S_M2, S_M3, S_DONE
  } state_e;

  // Configuration registers.
  logic [31:0] phase_step_q;
  logic [2:0]  mode_q;
  logic [31:0] right_ofs_q;
  logic [18:0] base_q;
  logic [18:0] swing_q;
  logic [15:0] fb_q;
  logic [16:0] mix_q;
  logic [11:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= 32'd4474;
      mode_q       <= 3'd4;
      right_ofs_q  <= 32'd1073741824;
      base_q       <= 19'd24576;
      swing_q      <= 19'd24576;
      fb_q         <= 16'd0;
      mix_q        <= 17'd32768;
      len_q        <= 12'd2048;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
        CFG_MODE:       mode_q       <= cfg_data_i[2:0];
        CFG_RIGHT_OFS:  right_ofs_q  <= cfg_data_i;
        CFG_BASE_DELAY: base_q       <= cfg_data_i[18:0];
        CFG_SWING:      swing_q      <= cfg_data_i[18:0];
        CFG_FEEDBACK:   fb_q         <= cfg_data_i[15:0];
        CFG_WET_MIX:    mix_q        <= cfg_data_i[16:0];
        CFG_LINE_LEN:   len_q        <= cfg_data_i[11:0];
        default:        ;
      endcase
    end
  end

  // Out-of-range settings act as their nearest legal value.
  logic [LEN_W-1:0] len_eff;
  logic [15:0]      fb_eff;
  logic [16:0]      mix_eff;
  logic [MOD_W-1:0] span;

  always_comb begin
    len_eff = LEN_W'(len_q);
    if (len_q < 12'd2) len_eff = LEN_W'(2);
    else if (len_q > 12'(LINE_DEPTH)) len_eff = LEN_W'(LINE_DEPTH);
    fb_eff  = (fb_q > 16'(FB_LIMIT)) ? 16'(FB_LIMIT) : fb_q;
    mix_eff = (mix_q > 17'(MIX_ONE)) ? 17'(MIX_ONE) : mix_q;
  end

  assign span = {len_eff, {DELAY_FRAC{1'b0}}};

  // Sequencer state and per-item registers.
  state_e                   state_q;
  logic [LINE_AW-1:0]       clr_q;
  logic                     ch_q;
  logic [LINE_AW-1:0]       w_q;
  logic [31:0]              phase_q;
  sample_t                  xl_q;
  sample_t                  xr_q;
  sample_t                  yl_q;
  sample_t                  yr_q;
  sample_t                  a0_q;
  sample_t                  a1_q;
  sample_t                  wet_q;
  logic signed [MUL_PW-1:0] acc_q;
  logic                     neg_q;
  logic [LINE_AW-1:0]       i0_q;
  logic [LINE_AW-1:0]       i1_q;
  logic [DELAY_FRAC-1:0]    fr_q;
  logic                     out_valid_q;
  sample_t                  lout_q;
  sample_t                  rout_q;

  // Shared arithmetic units.
  mul_req_t                 mul_req;
  logic                     mul_done;
  logic signed [MUL_PW-1:0] mul_p;
  mod_req_t                 mod_req;
  logic                     mod_done;
  logic [MOD_W-1:0]         mod_rem;
  logic signed [16:0]       lfo_val;

  sf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  sf_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  sf_lfo u_lfo (
    .clk_i   (clk_i),
    .phase_i (ch_q ? phase_q + right_ofs_q : phase_q),
    .shape_i (mode_q[1:0]),
    .lfo_o   (lfo_val)
  );

  // Delay-line memories, one write and one read port each.
  sample_t            left_line  [0:LINE_DEPTH-1];
  sample_t            right_line [0:LINE_DEPTH-1];
  sample_t            rd_l_q;
  sample_t            rd_r_q;
  sample_t            rdata;
  logic [LINE_AW-1:0] rd_addr;
  logic               we_l;
  logic               we_r;
  logic [LINE_AW-1:0] waddr;
  sample_t            wdata;

  // Datapath arithmetic on the multiplier result.
  sample_t                x_cur;
  logic signed [MUL_PW:0] fb_sum;
  sample_t                new_sample;
  logic signed [MUL_PW:0] dly;
  logic signed [MUL_PW:0] dpos;
  logic [MOD_W-1:0]       dpos_abs;
  logic [MOD_W-1:0]       pos;
  logic [LINE_AW-1:0]     i0;
  logic [LEN_W-1:0]       i1_full;
  logic signed [MUL_PW:0] wet_sum;
  logic signed [MUL_PW:0] mix_sum;
  logic [LEN_W-1:0]       w_next;
  logic                   in_acc;
  logic                   out_free;

  assign x_cur = ch_q ? xr_q : xl_q;
  assign rdata = ch_q ? rd_r_q : rd_l_q;

  always_comb begin
    fb_sum     = (MUL_PW + 1)'(x_cur) +
                 (((MUL_PW + 1)'(mul_p) + (MUL_PW + 1)'(32768)) >>> 16);
    new_sample = sat_sample(fb_sum);
    dly        = (MUL_PW + 1)'($signed({1'b0, base_q})) + ((MUL_PW + 1)'(mul_p) >>> 15);
    dpos       = (MUL_PW + 1)'($signed({1'b0, w_q, {DELAY_FRAC{1'b0}}})) - dly;
    dpos_abs   = dpos[MUL_PW] ? MOD_W'(-dpos) : MOD_W'(dpos);
    if (!neg_q)              pos = mod_rem;
    else if (mod_rem == '0)  pos = '0;
    else                     pos = span - mod_rem;
    i0      = pos[DELAY_FRAC +: LINE_AW];
    i1_full = LEN_W'(i0) + 1'b1;
    wet_sum = (MUL_PW + 1)'(acc_q) + (MUL_PW + 1)'(mul_p) +
              (MUL_PW + 1)'(1 << (DELAY_FRAC - 1));
    mix_sum = ((MUL_PW + 1)'(acc_q) + (MUL_PW + 1)'(mul_p) +
               (MUL_PW + 1)'(32768)) >>> 16;
    w_next  = LEN_W'(w_q) + 1'b1;
  end

  // Multiplier and remainder requests issued by the sequencer.
  always_comb begin
    mul_req = '0;
    mod_req = '0;
    case (state_q)
      S_FBSTART: begin
        mul_req.start = 1'b1;
        mul_req.a     = rdata;
        mul_req.b     = MUL_BW'(fb_eff);
      end
      S_FBMUL: begin
        mul_req.start = mul_done;
        mul_req.a     = MUL_AW'(lfo_val);
        mul_req.b     = swing_q;
      end
      S_DMUL: begin
        mod_req.start = mul_done;
        mod_req.num   = dpos_abs;
        mod_req.den   = span;
      end
      S_RD2: begin
        mul_req.start = 1'b1;
        mul_req.a     = a0_q;
        mul_req.b     = MUL_BW'(10'(1 << DELAY_FRAC) - 10'(fr_q));
      end
      S_M0: begin
        mul_req.start = mul_done;
        mul_req.a     = a1_q;
        mul_req.b     = MUL_BW'(fr_q);
      end
      S_M1: begin
        mul_req.start = mul_done;
        mul_req.a     = x_cur;
        mul_req.b     = MUL_BW'(17'(MIX_ONE) - mix_eff);
      end
      S_M2: begin
        mul_req.start = mul_done;
        mul_req.a     = wet_q;
        mul_req.b     = MUL_BW'(mix_eff);
      end
      default: ;
    endcase
  end

  // Memory port control.
  always_comb begin
    case (state_q)
      S_RD0:   rd_addr = i0_q;
      S_RD1:   rd_addr = i1_q;
      default: rd_addr = w_q;
    endcase
    we_l  = 1'b0;
    we_r  = 1'b0;
    waddr = w_q;
    wdata = new_sample;
    if (state_q == S_CLR) begin
      we_l  = 1'b1;
      we_r  = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (state_q == S_FBMUL && mul_done) begin
      we_l = !ch_q;
      we_r = ch_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_l) left_line[waddr] <= wdata;
    if (we_r) right_line[waddr] <= wdata;
    rd_l_q <= left_line[rd_addr];
    rd_r_q <= right_line[rd_addr];
  end

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: one channel at a time, each product through the serial multiplier.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      ch_q        <= 1'b0;
      w_q         <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The final step reloads the output register itself.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LINE_AW'(LINE_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            xl_q    <= left_in_i;
            xr_q    <= right_in_i;
            yr_q    <= right_in_i;
            ch_q    <= 1'b0;
            // A write index left past a shortened line restarts at the top.
            if (LEN_W'(w_q) >= len_eff) w_q <= '0;
            state_q <= S_RDOLD;
          end
        end
        S_RDOLD:   state_q <= S_LFO;
        S_LFO:     state_q <= S_FBSTART;
        S_FBSTART: state_q <= S_FBMUL;
        S_FBMUL:   if (mul_done) state_q <= S_DMUL;
        S_DMUL: begin
          if (mul_done) begin
            neg_q   <= dpos[MUL_PW];
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            i0_q    <= i0;
            i1_q    <= (i1_full >= len_eff) ? '0 : i1_full[LINE_AW-1:0];
            fr_q    <= pos[DELAY_FRAC-1:0];
            state_q <= S_RD0;
          end
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: begin
          a0_q    <= rdata;
          state_q <= S_RD2;
        end
        S_RD2: begin
          a1_q    <= rdata;
          state_q <= S_M0;
        end
        S_M0: begin
          if (mul_done) begin
            acc_q   <= mul_p;
            state_q <= S_M1;
          end
        end
        S_M1: begin
          if (mul_done) begin
            wet_q   <= wet_sum[DELAY_FRAC +: SAMPLE_BITS];
            state_q <= S_M2;
          end
        end
        S_M2: begin
          if (mul_done) begin
            acc_q   <= mul_p;
            state_q <= S_M3;
          end
        end
        S_M3: begin
          if (mul_done) begin
            if (ch_q) yr_q <= sat_sample(mix_sum);
            else      yl_q <= sat_sample(mix_sum);
            if (!ch_q && mode_q[2]) begin
              ch_q    <= 1'b1;
              state_q <= S_RDOLD;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            lout_q      <= yl_q;
            rout_q      <= yr_q;
            out_valid_q <= 1'b1;
            w_q         <= (w_next >= len_eff) ? '0 : w_next[LINE_AW-1:0];
            phase_q     <= phase_q + phase_step_q;
            ch_q        <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = lout_q;
  assign right_out_o = rout_q;

  // A product only completes while the sequencer waits on one.
  a_mul_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_FBMUL || state_q == S_DMUL || state_q == S_M0 ||
                  state_q == S_M1 || state_q == S_M2 || state_q == S_M3))
    else $error("multiplier finished outside a multiply wait state");

  // The remainder unit is only started for, and finishes in, the wrap step.
  a_mod_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_MOD)
    else $error("remainder unit finished outside the wrap step");

  // An accepted request starts with the read of the entry to be overwritten.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RDOLD && !ch_q))
    else $error("accepted request did not start on the left channel");

endmodule

### tb/sv/stereo_flanger_tb.sv
// Self-checking testbench for the stereo flanger: drives sample pairs through the
// valid/stall channels and compares every output pair with an in-bench predictor.
// Depends on sf_pkg and the stereo_flanger RTL.
`timescale 1ns / 100ps

module stereo_flanger_tb;
  import sf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [23:0] left_in_i;
  logic [23:0] right_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [23:0] left_out_o;
  logic [23:0] right_out_o;

  stereo_flanger u_top (.*);

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Predictor state: its own copy of the delay lines, pointers and registers.
  int signed   pl_line [LINE_DEPTH];
  int signed   pr_line [LINE_DEPTH];
  int unsigned p_widx;
  int unsigned p_phase;
  int unsigned r_step, r_mode, r_rofs, r_base, r_swing, r_fb, r_mix, r_len;
  int          qsine [SINE_DEPTH+1];

  // Expected output pairs, oldest first.
  logic [23:0] exp_left_q[$];
  logic [23:0] exp_right_q[$];

  int  errors;
  int  send_idle_pct;
  int  stall_pct;
  bit  hold_off;

  // Quarter-wave sine table built from the same odd polynomial, 64-bit unsigned.
  function automatic void build_quarter_sine();
    longint unsigned t, t2, r, s;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      t  = (longint'(k) << 30) / SINE_DEPTH;
      t2 = (t * t) >> 30;
      r  = 64'd5026995 - ((t2 * 64'd172272) >> 30);
      r  = 64'd85569306 - ((t2 * r) >> 30);
      r  = 64'd693598668 - ((t2 * r) >> 30);
      r  = 64'd1686629713 - ((t2 * r) >> 30);
      s  = (((t * r) >> 30) + (64'd1 << 14)) >> 15;
      qsine[k] = (s > 32767) ? 32767 : int'(s);
    end
  endfunction

  function automatic longint lfo_of(int unsigned u, int unsigned shape);
    int unsigned q, idx;
    longint v;
    if (shape == SHAPE_TRIANGLE) begin
      if (u < 32'h8000_0000) return longint'(u >> 15) - 32768;
      return 98304 - longint'(u >> 15);
    end
    if (shape == SHAPE_SAWTOOTH) return 32768 - longint'(u >> 16);
    q   = u >> 30;
    idx = int'((longint'(u & 32'h3FFF_FFFF) * SINE_DEPTH) >> 30);
    if (q[0]) idx = SINE_DEPTH - idx;
    v = qsine[idx];
    return q[1] ? -v : v;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // One channel: feedback write, interpolated delayed read, dry/wet mix.
  function automatic longint flange_channel(longint x, bit right_side, int unsigned w,
                                            int unsigned len, int unsigned ph,
                                            longint fb, longint mix);
    longint old, d, span, pos, acc, wet, a0, a1;
    int unsigned i0, i1, fr;
    old = right_side ? pr_line[w] : pl_line[w];
    if (right_side) pr_line[w] = int'(clip24(x + ((old * fb + 32768) >>> 16)));
    else            pl_line[w] = int'(clip24(x + ((old * fb + 32768) >>> 16)));
    d    = longint'(r_base) + ((longint'(r_swing) * lfo_of(ph, r_mode & 3)) >>> 15);
    span = longint'(len) << DELAY_FRAC;
    pos  = ((longint'(w) << DELAY_FRAC) - d) % span;
    if (pos < 0) pos += span;
    i0 = int'(pos >> DELAY_FRAC);
    fr = int'(pos & 255);
    i1 = i0 + 1;
    if (i1 >= len) i1 = 0;
    a0 = right_side ? pr_line[i0] : pl_line[i0];
    a1 = right_side ? pr_line[i1] : pl_line[i1];
    acc = a0 * (256 - fr) + a1 * fr;
    wet = (acc + 128) >>> DELAY_FRAC;
    return clip24((x * (65536 - mix) + wet * mix + 32768) >>> 16);
  endfunction

  // Works out the output pair of one accepted request and queues it.
  function automatic void predict_pair(logic [23:0] lin, logic [23:0] rin);
    int unsigned len;
    longint fb, mix, yl, yr;
    len = (r_len < 2) ? 2 : ((r_len > LINE_DEPTH) ? LINE_DEPTH : r_len);
    fb  = (r_fb > FB_LIMIT) ? FB_LIMIT : r_fb;
    mix = (r_mix > MIX_ONE) ? MIX_ONE : r_mix;
    if (p_widx >= len) p_widx = 0;
    yl = flange_channel(longint'(sample_t'(lin)), 1'b0, p_widx, len, p_phase, fb, mix);
    if (r_mode[2])
      yr = flange_channel(longint'(sample_t'(rin)), 1'b1, p_widx, len,
                          p_phase + r_rofs, fb, mix);
    else
      yr = longint'(sample_t'(rin));
    p_widx++;
    if (p_widx >= len) p_widx = 0;
    p_phase += r_step;
    exp_left_q.push_back(yl[23:0]);
    exp_right_q.push_back(yr[23:0]);
  endfunction

  // Register write, done while the block is idle; the predictor follows it.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PHASE_STEP: r_step  = val;
      CFG_MODE:       r_mode  = val & 7;
      CFG_RIGHT_OFS:  r_rofs  = val;
      CFG_BASE_DELAY: r_base  = val & 32'h7FFFF;
      CFG_SWING:      r_swing = val & 32'h7FFFF;
      CFG_FEEDBACK:   r_fb    = val & 32'hFFFF;
      CFG_WET_MIX:    r_mix   = val & 32'h1FFFF;
      CFG_LINE_LEN:   r_len   = val & 32'hFFF;
      default: ;
    endcase
  endtask

  // Sends one request; inputs change on the falling edge, acceptance is seen
  // at the rising edge. Valid stays high between back-to-back requests.
  task automatic send_pair(logic [23:0] lin, logic [23:0] rin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i  <= lin;
    right_in_i <= rin;
    do @(posedge clk_i); while (in_stall_o);
    predict_pair(lin, rin);
    @(negedge clk_i);
  endtask

  task automatic drain_and_pause();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (exp_left_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(255)) - 24'd128;
      default: return 24'($urandom);
    endcase
  endfunction

  // Receiver: random stall and the checking of each accepted output pair.
  always @(negedge clk_i)
    if (rst_ni) out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_left_q.size() == 0) begin
        $display("%0t: output pair with nothing expected: %h %h", $time,
                 left_out_o, right_out_o);
        errors++;
      end else begin
        if (left_out_o !== exp_left_q[0]) begin
          $display("%0t: left_out expected %h actual %h", $time, exp_left_q[0],
                   left_out_o);
          errors++;
        end
        if (right_out_o !== exp_right_q[0]) begin
          $display("%0t: right_out expected %h actual %h", $time, exp_right_q[0],
                   right_out_o);
          errors++;
        end
        void'(exp_left_q.pop_front());
        void'(exp_right_q.pop_front());
      end
    end
  end

  // Field extremes, every shape, stereo on and off, with defaults.
  task automatic test_directed();
    logic [23:0] edges[6] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                              24'h000001, 24'h555555};
    foreach (edges[i]) send_pair(edges[i], edges[5 - i]);
    for (int s = 0; s < 8; s++) begin
      drain_and_pause();
      write_reg(CFG_MODE, s);
      send_pair(24'hAAAAAA, 24'h7FFFFF);
      send_pair(24'h800000, 24'h555555);
    end
  endtask

  // Corner settings: oversized registers, short lines, large delays, full feedback.
  task automatic test_corners();
    drain_and_pause();
    write_reg(CFG_LINE_LEN, 0);
    write_reg(CFG_FEEDBACK, 16'hFFFF);
    write_reg(CFG_WET_MIX, 32'h1FFFF);
    write_reg(CFG_BASE_DELAY, 524032);
    write_reg(CFG_SWING, 524032);
    write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_RIGHT_OFS, 32'hFFFF_FFFF);
    write_reg(CFG_MODE, 5);
    for (int i = 0; i < 6; i++) send_pair(rand_sample(), rand_sample());
    drain_and_pause();
    // Length above the line depth, then shrink so the write pointer restarts.
    write_reg(CFG_LINE_LEN, 12'hFFF);
    write_reg(CFG_BASE_DELAY, 0);
    write_reg(CFG_MODE, 6);
    for (int i = 0; i < 5; i++) send_pair(rand_sample(), rand_sample());
    drain_and_pause();
    write_reg(CFG_LINE_LEN, 3);
    for (int i = 0; i < 5; i++) send_pair(rand_sample(), rand_sample());
  endtask

  // Random settings per phase; mostly short lines so feedback builds up.
  task automatic test_random(int n_items);
    drain_and_pause();
    write_reg(CFG_PHASE_STEP, $urandom);
    write_reg(CFG_MODE, $urandom_range(7));
    write_reg(CFG_RIGHT_OFS, $urandom);
    write_reg(CFG_BASE_DELAY, $urandom_range(524032));
    write_reg(CFG_SWING, ($urandom_range(1)) ? $urandom_range(524032)
                                              : $urandom_range(4096));
    write_reg(CFG_FEEDBACK, $urandom_range(65535));
    write_reg(CFG_WET_MIX, $urandom_range(70000));
    write_reg(CFG_LINE_LEN, ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                      : $urandom_range(2, 64));
    for (int i = 0; i < n_items; i++) send_pair(rand_sample(), rand_sample());
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    drain_and_pause();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_pair(rand_sample(), rand_sample());
    join
  endtask

  initial begin
    errors = 0; hold_off = 1'b0; send_idle_pct = 0; stall_pct = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = CFG_PHASE_STEP; cfg_data_i = '0;
    in_valid_i = 1'b0; left_in_i = '0; right_in_i = '0; out_stall_i = 1'b0;
    build_quarter_sine();
    foreach (pl_line[i]) begin pl_line[i] = 0; pr_line[i] = 0; end
    p_widx = 0; p_phase = 0;
    r_step = 4474; r_mode = 4; r_rofs = 32'h4000_0000; r_base = 24576;
    r_swing = 24576; r_fb = 0; r_mix = 32768; r_len = 2048;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_corners();
    test_backpressure();
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      test_random(50);
    end
    drain_and_pause();

    if (errors == 0 && exp_left_q.size() == 0) $display("PASS stereo_flanger");
    else $display("FAIL stereo_flanger");
    $finish;
  end

  // Watchdog: bounds a run of about 1300 requests, with stalls.
  initial begin
    #200ms;
    $display("FAIL stereo_flanger");
    $finish;
  end

endmodule

### files.f
rtl/sf_pkg.sv
rtl/sf_mul.sv
rtl/sf_mod.sv
rtl/sf_lfo.sv
rtl/stereo_flanger.sv
tb/sv/stereo_flanger_tb.sv
